// ===== design/sob_pkg.sv =====
// Shared types and constants for the Sobel horizontal gradient block.
// No dependencies; used by every other file of the block but sob_line_ram.
package sob_pkg;

	// Payload and register widths
	localparam int PixW   = 8;
	localparam int CfgW   = 11;
	localparam int CoordW = 10;
	localparam int IdxW   = 1;

	// Default frame bounds and register reset values
	localparam int DefaultMaxWidth  = 1024;
	localparam int DefaultMaxHeight = 1024;
	localparam logic [CfgW-1:0] FrameWidthReset  = 11'd640;
	localparam logic [CfgW-1:0] FrameHeightReset = 11'd480;

	// Register indexes of the configuration port
	localparam logic [IdxW-1:0] RegFrameWidth  = 1'd0;
	localparam logic [IdxW-1:0] RegFrameHeight = 1'd1;

	// Largest edge strength
	localparam logic [PixW-1:0] StrengthMax = 8'd255;

	// One column of the 3x3 window: top, middle and bottom rows
	typedef struct packed {
		logic [PixW-1:0] top;
		logic [PixW-1:0] mid;
		logic [PixW-1:0] bot;
	} column_t;

endpackage

// ===== design/sob_line_ram.sv =====
// Two-row line store: one write port, one read port with registered data.
// Depends on nothing; the top level sets depth and word width.
module sob_line_ram #(
	parameter int DEPTH = 1024,
	parameter int DW    = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [0:DEPTH-1];
	logic [DW-1:0] rdata_q;

	// Write the retiring item's rows
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read on accept, hold otherwise
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/sob_cell.sv =====
// One window cell: holds a column of three pixels and passes it on.
// Depends on sob_pkg for the column type.
module sob_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  sob_pkg::column_t col_in,
	output sob_pkg::column_t col_out
);

	sob_pkg::column_t col_q;

	// Advance the column when the window shifts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

// ===== design/sob_gradient.sv =====
// Horizontal Sobel gradient of a window: weighted right column minus left,
// magnitude clamped to the pixel range. Depends on sob_pkg.
module sob_gradient (
	input  sob_pkg::column_t             left,
	input  sob_pkg::column_t             right,
	output logic [sob_pkg::PixW-1:0]     strength
);

	localparam int SumW = sob_pkg::PixW + 2;

	logic [SumW-1:0] sum_left;
	logic [SumW-1:0] sum_right;
	logic [SumW-1:0] mag;

	// Weight rows 1, 2, 1
	assign sum_left  = SumW'(left.top) + SumW'(left.bot) + (SumW'(left.mid) << 1);
	assign sum_right = SumW'(right.top) + SumW'(right.bot) + (SumW'(right.mid) << 1);

	// Absolute difference, then clamp
	always_comb begin
		if (sum_right >= sum_left) begin
			mag = sum_right - sum_left;
		end else begin
			mag = sum_left - sum_right;
		end
		if (mag > SumW'(sob_pkg::StrengthMax)) begin
			strength = sob_pkg::StrengthMax;
		end else begin
			strength = mag[sob_pkg::PixW-1:0];
		end
	end

endmodule

// ===== design/sobel_horizontal_gradient.sv =====
// Top level of the Sobel horizontal gradient stream block.
// Depends on sob_pkg, sob_line_ram, sob_cell and sob_gradient.
//
// Usage:
// Pixels enter in raster order on the pixel channel (pixel_valid/pixel_ready),
// frame_start marks the first pixel of a frame. For every pixel at row >= 2
// and column >= 2 one result leaves on the result channel
// (result_valid/result_ready): the clamped horizontal gradient of the 3x3
// window centered one row up and one column left, its center coordinates, and
// frame_done on the last pixel of the frame. Border pixels give no result.
// Throughput is one pixel per cycle while results are taken. An accepted
// pixel passes the registered line store read, then the window and gradient
// into the output register. The user must write frame_width and frame_height
// on the cfg channel (index 0 and 1) only while the block is idle; the block
// itself does not enforce this. Out-of-range values are clamped to 3..MAX.
// Reset clears position, window and handshake state and restores 640x480;
// line store contents are undefined until the first two rows are written.
// When the receiver stalls, the result holds in the output register and the
// read stage takes pixels until one that gives a result drops pixel_ready.
module sobel_horizontal_gradient #(
	parameter int MAX_WIDTH  = sob_pkg::DefaultMaxWidth,
	parameter int MAX_HEIGHT = sob_pkg::DefaultMaxHeight
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sob_pkg::IdxW-1:0]      cfg_index,
	input  logic [sob_pkg::CfgW-1:0]      cfg_data,
	input  logic                          pixel_valid,
	output logic                          pixel_ready,
	input  logic [sob_pkg::PixW-1:0]      pixel_value,
	input  logic                          frame_start,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [sob_pkg::PixW-1:0]      edge_strength,
	output logic [sob_pkg::CoordW-1:0]    center_row,
	output logic [sob_pkg::CoordW-1:0]    center_col,
	output logic                          frame_done
);

	localparam int PixW   = sob_pkg::PixW;
	localparam int CfgW   = sob_pkg::CfgW;
	localparam int CoordW = sob_pkg::CoordW;
	localparam int ColW   = $clog2(MAX_WIDTH);
	localparam int RowW   = $clog2(MAX_HEIGHT);
	localparam int WCmpW  = (ColW + 1 > CfgW) ? ColW + 1 : CfgW;
	localparam int HCmpW  = (RowW + 1 > CfgW) ? RowW + 1 : CfgW;
	localparam int ColXW  = (ColW > CoordW) ? ColW : CoordW;
	localparam int RowXW  = (RowW > CoordW) ? RowW : CoordW;
	localparam int NumCells = 2;

	// Configuration registers
	logic [CfgW-1:0] frame_width_q;
	logic [CfgW-1:0] frame_height_q;

	// Position of the next pixel
	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;

	// Read stage
	logic               valid_s1;
	logic [PixW-1:0]    pix_s1;
	logic [ColW-1:0]    col_s1;
	logic [RowW-1:0]    row_s1;
	logic               prod_s1;
	logic               done_s1;
	logic               hit_s1;
	logic [2*PixW-1:0]  fwd_s1;

	// Output register
	logic                valid_s2;
	logic [PixW-1:0]     strength_s2;
	logic [CoordW-1:0]   row_s2;
	logic [CoordW-1:0]   col_s2;
	logic                done_s2;

	logic [WCmpW-1:0]    fw_x;
	logic [HCmpW-1:0]    fh_x;
	logic [ColW-1:0]     w_last;
	logic [RowW-1:0]     h_last;
	logic [ColW-1:0]     c_new;
	logic [RowW-1:0]     r_new;
	logic                last_col;
	logic                last_row;
	logic                accept;
	logic                adv_s1;
	logic [2*PixW-1:0]   rd_data;
	logic [2*PixW-1:0]   rows_s1;
	logic [PixW-1:0]     top_s1;
	logic [PixW-1:0]     mid_s1;
	logic [PixW-1:0]     strength;
	logic [RowXW-1:0]    row_c;
	logic [ColXW-1:0]    col_c;
	sob_pkg::column_t    chain [0:NumCells];

	// Take register writes at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= sob_pkg::FrameWidthReset;
			frame_height_q <= sob_pkg::FrameHeightReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sob_pkg::RegFrameWidth:  frame_width_q  <= cfg_data;
				sob_pkg::RegFrameHeight: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the frame size and form the last column and row
	assign fw_x = WCmpW'(frame_width_q);
	assign fh_x = HCmpW'(frame_height_q);

	always_comb begin
		if (fw_x < WCmpW'(3)) begin
			w_last = ColW'(2);
		end else if (fw_x > WCmpW'(MAX_WIDTH)) begin
			w_last = ColW'(MAX_WIDTH - 1);
		end else begin
			w_last = ColW'(fw_x - WCmpW'(1));
		end
		if (fh_x < HCmpW'(3)) begin
			h_last = RowW'(2);
		end else if (fh_x > HCmpW'(MAX_HEIGHT)) begin
			h_last = RowW'(MAX_HEIGHT - 1);
		end else begin
			h_last = RowW'(fh_x - HCmpW'(1));
		end
	end

	// Position of the incoming item
	assign c_new    = frame_start ? '0 : col_q;
	assign r_new    = frame_start ? '0 : row_q;
	assign last_col = (c_new >= w_last);
	assign last_row = (r_new >= h_last);

	// Handshake: the read stage drains unless its result is blocked
	assign adv_s1      = valid_s1 && (!prod_s1 || !valid_s2 || result_ready);
	assign pixel_ready = !valid_s1 || adv_s1;
	assign accept      = pixel_valid && pixel_ready;

	// Advance the raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : r_new + RowW'(1);
			end else begin
				col_q <= c_new + ColW'(1);
				row_q <= r_new;
			end
		end
	end

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Read stage payload; forward the retiring write on a same-column hit
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel_value;
			col_s1  <= c_new;
			row_s1  <= r_new;
			prod_s1 <= (r_new >= RowW'(2)) && (c_new >= ColW'(2));
			done_s1 <= last_col && last_row;
			hit_s1  <= adv_s1 && (col_s1 == c_new);
			fwd_s1  <= {mid_s1, pix_s1};
		end
	end

	sob_line_ram #(
		.DEPTH (MAX_WIDTH),
		.DW    (2 * PixW),
		.AW    (ColW)
	) u_line_ram (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (col_s1),
		.wdata ({mid_s1, pix_s1}),
		.re    (accept),
		.raddr (c_new),
		.rdata (rd_data)
	);

	assign rows_s1 = hit_s1 ? fwd_s1 : rd_data;
	assign top_s1  = rows_s1[2*PixW-1:PixW];
	assign mid_s1  = rows_s1[PixW-1:0];

	// Window: chain of column cells, newest column at the head
	assign chain[0] = '{top: top_s1, mid: mid_s1, bot: pix_s1};

	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		sob_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (adv_s1),
			.col_in  (chain[i]),
			.col_out (chain[i+1])
		);
	end

	sob_gradient u_gradient (
		.left     (chain[NumCells]),
		.right    (chain[0]),
		.strength (strength)
	);

	// Center is one row up and one column left
	assign row_c = RowXW'(row_s1) - RowXW'(1);
	assign col_c = ColXW'(col_s1) - ColXW'(1);

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && prod_s1) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (adv_s1 && prod_s1) begin
			strength_s2 <= strength;
			row_s2      <= row_c[CoordW-1:0];
			col_s2      <= col_c[CoordW-1:0];
			done_s2     <= done_s1;
		end
	end

	assign result_valid  = valid_s2;
	assign edge_strength = strength_s2;
	assign center_row    = row_s2;
	assign center_col    = col_s2;
	assign frame_done    = done_s2;

endmodule

// ===== design/sob_checker.sv =====
// Port-level checks for the Sobel horizontal gradient block, and its bind.
// Depends on sob_pkg and the top level sobel_horizontal_gradient.
module sob_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pixel_valid,
	input logic                          pixel_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [sob_pkg::PixW-1:0]      edge_strength,
	input logic [sob_pkg::CoordW-1:0]    center_row,
	input logic [sob_pkg::CoordW-1:0]    center_col,
	input logic                          frame_done
);

	// Hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// Keep a stalled payload steady
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(edge_strength) && $stable(center_row)
			&& $stable(center_col) && $stable(frame_done))
		else $error("result payload changed while stalled");

	// An empty output register never blocks the pixel side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> pixel_ready)
		else $error("pixel side stalled with no result pending");

	// A new result traces back through the read stage and output register to an accepted pixel
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(pixel_valid && pixel_ready, 2))
		else $error("result without a matching pixel");

endmodule

bind sobel_horizontal_gradient sob_checker u_sob_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pixel_valid   (pixel_valid),
	.pixel_ready   (pixel_ready),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.edge_strength (edge_strength),
	.center_row    (center_row),
	.center_col    (center_col),
	.frame_done    (frame_done)
);
